@@ hdl/gf2_pivot_row_reducer_defines.svh @@
// ----------------------------------------------------------------------------
// gf2_pivot_row_reducer_defines
// assertion macros shared by the checker of the row reducer
// ----------------------------------------------------------------------------
`ifndef GF2_PIVOT_ROW_REDUCER_DEFINES_SVH
`define GF2_PIVOT_ROW_REDUCER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define GPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define GPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/gpr_pkg.sv @@
// ----------------------------------------------------------------------------
// gpr_pkg
// request and response types, mode codes and helpers of the row reducer
// ----------------------------------------------------------------------------
package gpr_pkg;

    localparam int COL_W  = 10;
    localparam int DATA_W = 32;
    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_SET    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COMMIT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REDUCE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [COL_W-1:0]  column;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [COL_W-1:0]  leading_col;
        logic              row_empty;
        logic              promoted;
        logic              rejected;
    } t_rsp;

    // position of the highest set bit, binary search in five halving steps
    function automatic logic [4:0] gpr_msb32(logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] t;
        logic [4:0]        p;
        t = v;
        p = '0;
        for (int k = 4; k >= 0; k--) begin
            if ((t >> (1 << k)) != '0) begin
                p[k] = 1'b1;
                t    = t >> (1 << k);
            end
        end
        return p;
    endfunction

endpackage

@@ hdl/gpr_if.sv @@
// ----------------------------------------------------------------------------
// gpr_if
// valid/ready channels carrying requests and responses of the row reducer
// ----------------------------------------------------------------------------
interface gpr_req_if import gpr_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface gpr_rsp_if import gpr_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/gf2_pivot_row_reducer.sv @@
// ----------------------------------------------------------------------------
// gf2_pivot_row_reducer
// GF(2) staging row with a pivot table, reduced by one shared word XOR unit
// ----------------------------------------------------------------------------
// i_req carries one request (mode, column); o_rsp returns exactly one response
// per request, in order. A request is taken at an edge with valid and ready
// high; ready is high only while the sequencer is idle.
// After reset a sweep clears the pivot-valid store, one 32-bit row a cycle,
// with ready low. Set and read pass through a staging read, a write or
// capture, and the response load; clear, unused modes, an out-of-range set
// or read and a commit or reduce of an empty row go straight to the response
// load. Otherwise commit and reduce check the pivot-valid bit of the leading
// column, then run an XOR pass or, with no pivot yet, the final copy into
// the pivot table, word by word from the leading staging word down, before
// the response; a commit that finds a pivot is refused after the check.
// Each further pivot a reduce eliminates adds a lookup and a pass. ready
// returns the cycle after the response loads, so one request is in work at
// a time. The staging and pivot memories each give one word per access.
// The response waits in its output register while the receiver stalls; the
// next request is taken meanwhile and its response holds in the sequencer
// until the register frees.
// ----------------------------------------------------------------------------
module gf2_pivot_row_reducer import gpr_pkg::*; #(
    parameter int COLUMNS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gpr_req_if.sink   i_req,
    gpr_rsp_if.source o_rsp
);

    localparam int LW    = $clog2(COLUMNS);
    localparam int WW    = LW - 5;
    localparam int WORDS = (COLUMNS + 31) / 32;
    localparam int XW    = ((LW > COL_W) ? LW : COL_W) + 1;

    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_VRD  = 7'b0000100,
        S_VCHK = 7'b0001000,
        S_RD   = 7'b0010000,
        S_WR   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    typedef enum logic [2:0] {
        OP_SET,
        OP_READ,
        OP_COMMIT,
        OP_REDUCE,
        OP_XOR,
        OP_COPY
    } t_op;

    // memories
    logic [DATA_W-1:0] r_stg_mem  [WORDS];
    logic [DATA_W-1:0] r_piv_mem  [COLUMNS << WW];
    logic [DATA_W-1:0] r_pvld_mem [WORDS];

    // control state
    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [WW-1:0]     r_widx, n_widx;
    logic [LW-1:0]     r_lead, n_lead;
    logic              r_empty, n_empty;
    logic              r_found, n_found;
    logic [LW-1:0]     r_nlead, n_nlead;
    logic [WORDS-1:0]  r_svalid, n_svalid;
    logic              r_out_vld, n_out_vld;

    // payload
    logic [4:0]        r_bit, n_bit;
    logic              r_promoted, n_promoted;
    logic              r_rejected, n_rejected;
    logic [DATA_W-1:0] r_rdata, n_rdata;
    t_rsp              r_out, n_out;
    logic [DATA_W-1:0] r_stg_q;
    logic              r_stg_vq;
    logic [DATA_W-1:0] r_piv_q;
    logic [DATA_W-1:0] r_vq;

    // memory write ports
    logic              stg_we;
    logic [DATA_W-1:0] stg_wdata;
    logic              piv_we;
    logic              pvld_we;
    logic [WW-1:0]     pvld_waddr;
    logic [DATA_W-1:0] pvld_wdata;

    logic [XW-1:0]     col_x;
    logic              col_in_rng;
    logic [LW-1:0]     col_l;
    logic [DATA_W-1:0] stg_word;
    logic [DATA_W-1:0] xor_word;
    logic [WW-1:0]     lead_word;
    logic [LW-1:0]     set_col;
    logic [LW-1:0]     xor_lead;
    logic              xor_hit;
    logic              found_now;
    logic [LW-1:0]     lead_now;
    logic [XW-1:0]     lead_x;

    assign col_x      = XW'(i_req.payload.column);
    assign col_in_rng = col_x < XW'(COLUMNS);
    assign col_l      = col_x[LW-1:0];
    assign stg_word   = r_stg_vq ? r_stg_q : '0;
    assign xor_word   = stg_word ^ r_piv_q;
    assign lead_word  = r_lead[LW-1:5];
    assign set_col    = {r_widx, r_bit};
    assign xor_lead   = {r_widx, gpr_msb32(xor_word)};
    assign xor_hit    = xor_word != '0;
    assign found_now  = r_found | xor_hit;
    assign lead_now   = (!r_found && xor_hit) ? xor_lead : r_nlead;
    assign lead_x     = XW'(r_lead);

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_widx     = r_widx;
        n_lead     = r_lead;
        n_empty    = r_empty;
        n_found    = r_found;
        n_nlead    = r_nlead;
        n_svalid   = r_svalid;
        n_out_vld  = r_out_vld && !o_rsp.ready;
        n_bit      = r_bit;
        n_promoted = r_promoted;
        n_rejected = r_rejected;
        n_rdata    = r_rdata;
        n_out      = r_out;
        stg_we     = 1'b0;
        stg_wdata  = xor_word;
        piv_we     = 1'b0;
        pvld_we    = 1'b0;
        pvld_waddr = lead_word;
        pvld_wdata = '0;

        unique case (r_state)
            S_INIT: begin
                pvld_we    = 1'b1;
                pvld_waddr = r_widx;
                if (r_widx == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_widx = r_widx - WW'(1);
                end
            end

            S_IDLE: begin
                if (i_req.valid) begin
                    n_promoted = 1'b0;
                    n_rejected = 1'b0;
                    n_rdata    = '0;
                    n_state    = S_OUT;
                    unique case (i_req.payload.mode)
                        MODE_SET: begin
                            if (col_in_rng) begin
                                n_op    = OP_SET;
                                n_widx  = col_l[LW-1:5];
                                n_bit   = col_l[4:0];
                                n_state = S_RD;
                            end
                        end
                        MODE_COMMIT: begin
                            n_op = OP_COMMIT;
                            if (r_empty) begin
                                n_rejected = 1'b1;
                            end else begin
                                n_state = S_VRD;
                            end
                        end
                        MODE_REDUCE: begin
                            n_op = OP_REDUCE;
                            if (!r_empty) begin
                                n_state = S_VRD;
                            end
                        end
                        MODE_READ: begin
                            if (col_in_rng) begin
                                n_op    = OP_READ;
                                n_widx  = col_l[LW-1:5];
                                n_state = S_RD;
                            end
                        end
                        MODE_CLEAR: begin
                            n_svalid = '0;
                            n_lead   = '0;
                            n_empty  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_VRD: begin
                n_state = S_VCHK;
            end

            S_VCHK: begin
                n_widx = lead_word;
                if (r_vq[r_lead[4:0]]) begin
                    if (r_op == OP_COMMIT) begin
                        n_rejected = 1'b1;
                        n_state    = S_OUT;
                    end else begin
                        n_op    = OP_XOR;
                        n_found = 1'b0;
                        n_state = S_RD;
                    end
                end else begin
                    // no pivot yet: claim the slot, then copy the row into it
                    pvld_we    = 1'b1;
                    pvld_wdata = r_vq | (DATA_W'(1) << r_lead[4:0]);
                    n_promoted = 1'b1;
                    n_op       = OP_COPY;
                    n_state    = S_RD;
                end
            end

            S_RD: begin
                n_state = S_WR;
            end

            S_WR: begin
                n_state = S_RD;
                unique case (r_op)
                    OP_SET: begin
                        stg_we           = 1'b1;
                        stg_wdata        = stg_word | (DATA_W'(1) << r_bit);
                        n_svalid[r_widx] = 1'b1;
                        n_empty          = 1'b0;
                        if (r_empty || (set_col > r_lead)) begin
                            n_lead = set_col;
                        end
                        n_state = S_OUT;
                    end
                    OP_READ: begin
                        n_rdata = stg_word;
                        n_state = S_OUT;
                    end
                    OP_COPY: begin
                        piv_we = 1'b1;
                        if (r_widx == '0) begin
                            n_state = S_OUT;
                        end else begin
                            n_widx = r_widx - WW'(1);
                        end
                    end
                    OP_XOR: begin
                        stg_we           = 1'b1;
                        n_svalid[r_widx] = 1'b1;
                        n_found          = found_now;
                        n_nlead          = lead_now;
                        if (r_widx == '0) begin
                            // pass done: new leading column, then look up its pivot unless the row is empty
                            n_lead  = found_now ? lead_now : '0;
                            n_empty = !found_now;
                            n_state = found_now ? S_VRD : S_OUT;
                        end else begin
                            n_widx = r_widx - WW'(1);
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end

            S_OUT: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out.read_data   = r_rdata;
                    n_out.leading_col = lead_x[COL_W-1:0];
                    n_out.row_empty   = r_empty;
                    n_out.promoted    = r_promoted;
                    n_out.rejected    = r_rejected;
                    n_out_vld         = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_op      <= OP_SET;
            r_widx    <= WW'(WORDS - 1);
            r_lead    <= '0;
            r_empty   <= 1'b1;
            r_found   <= 1'b0;
            r_nlead   <= '0;
            r_svalid  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_widx    <= n_widx;
            r_lead    <= n_lead;
            r_empty   <= n_empty;
            r_found   <= n_found;
            r_nlead   <= n_nlead;
            r_svalid  <= n_svalid;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit      <= n_bit;
        r_promoted <= n_promoted;
        r_rejected <= n_rejected;
        r_rdata    <= n_rdata;
        r_out      <= n_out;
    end

    // staging row: one read, one write port
    always_ff @(posedge i_clk) begin
        if (stg_we) begin
            r_stg_mem[r_widx] <= stg_wdata;
        end
        if (r_state == S_RD) begin
            r_stg_q  <= r_stg_mem[r_widx];
            r_stg_vq <= r_svalid[r_widx];
        end
    end

    // pivot rows, addressed by {leading column, word}
    always_ff @(posedge i_clk) begin
        if (piv_we) begin
            r_piv_mem[{r_lead, r_widx}] <= stg_word;
        end
        if (r_state == S_RD) begin
            r_piv_q <= r_piv_mem[{r_lead, r_widx}];
        end
    end

    // pivot-valid bits, 32 columns per row
    always_ff @(posedge i_clk) begin
        if (pvld_we) begin
            r_pvld_mem[pvld_waddr] <= pvld_wdata;
        end
        if (r_state == S_VRD) begin
            r_vq <= r_pvld_mem[lead_word];
        end
    end

endmodule

@@ hdl/gpr_checker.sv @@
// ----------------------------------------------------------------------------
// gpr_checker
// port-level checks of the row reducer, bound to its top level
// ----------------------------------------------------------------------------
`include "gf2_pivot_row_reducer_defines.svh"

module gpr_checker import gpr_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp_payload
);

    // a stalled response stays put
    `GPR_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_payload), "response changed while stalled")

    // one request in work at a time
    `GPR_ASSERT_NEXT(a_busy_after_req, i_req_valid && i_req_ready, !i_req_ready, "ready stayed high after a request")

    // an empty row reports leading column zero
    `GPR_ASSERT_SAME(a_empty_lead, i_rsp_valid && i_rsp_payload.row_empty, i_rsp_payload.leading_col == '0, "empty row with nonzero leading column")

    // a row is never both promoted and rejected
    `GPR_ASSERT_SAME(a_flags_excl, i_rsp_valid, !(i_rsp_payload.promoted && i_rsp_payload.rejected), "promoted and rejected together")

    // a promotion leaves a nonempty row
    `GPR_ASSERT_SAME(a_promote_row, i_rsp_valid && i_rsp_payload.promoted, !i_rsp_payload.row_empty, "promoted an empty row")

endmodule

bind gf2_pivot_row_reducer gpr_checker u_gpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);
